[hdl/dle_pkg.sv]
`timescale 1ns / 1ps
package dle_pkg;
   localparam logic [7:0] DLE_BYTE = 8'h10;
   localparam logic [7:0] ETX_BYTE = 8'h03;

   localparam logic [1:0] CMD_BYTE    = 2'd0;
   localparam logic [1:0] CMD_READ    = 2'd1;
   localparam logic [1:0] CMD_RELEASE = 2'd2;

   localparam logic [1:0] REG_ACK_ID = 2'd0;
   localparam logic [1:0] REG_NAK_ID = 2'd1;
   localparam logic [1:0] REG_POS_ID = 2'd2;

   localparam logic [2:0] PH_START  = 3'd0;
   localparam logic [2:0] PH_ID     = 3'd1;
   localparam logic [2:0] PH_LEN    = 3'd2;
   localparam logic [2:0] PH_DATA   = 3'd3;
   localparam logic [2:0] PH_SUM    = 3'd4;
   localparam logic [2:0] PH_ENDDLE = 3'd5;
   localparam logic [2:0] PH_ETX    = 3'd6;
   localparam logic [2:0] PH_HELD   = 3'd7;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] rx_byte;
      logic [6:0] read_index;
   } req_type;
endpackage

[hdl/dle_ram.sv]
`timescale 1ns / 1ps
module dle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

[hdl/dle_fifo.sv]
`timescale 1ns / 1ps
module dle_fifo import dle_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output req_type out_data
);
   // two-entry queue, full throughput
   req_type    buf_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff, wr_ptr_in, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = buf_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) buf_ff[wr_ptr_ff] <= in_data;
   end
endmodule

[hdl/dle_engine.sv]
`timescale 1ns / 1ps
module dle_engine import dle_pkg::*; #(
   parameter int BUFFER_BYTES = 128
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  req_type    in_data,
   input  logic [7:0] ack_id,
   input  logic [7:0] nak_id,
   input  logic [7:0] pos_id,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_byte_accepted,
   output logic       rsp_frame_ready,
   output logic [7:0] rsp_frame_id,
   output logic [7:0] rsp_frame_length,
   output logic       rsp_ack_request,
   output logic [7:0] rsp_read_data,
   output logic       rsp_frame_held
);
   localparam int AW = $clog2(BUFFER_BYTES);
   localparam logic [7:0] BUF_LEN = 8'(BUFFER_BYTES);

   logic [2:0] phase_ff, phase_in;
   logic       esc_ff, esc_in;
   logic [7:0] sum_ff, sum_in, id_ff, id_in, len_ff, len_in;
   logic [7:0] rem_ff, rem_in, wpos_ff, wpos_in;
   logic       acc, ready, ack, wr_en, rd_hit;
   logic [7:0] s;
   logic [7:0] ridx;

   // output register: valid plus read data comes from the ram next cycle
   logic       ovalid_ff, oacc_ff, ordy_ff, oack_ff, oheld_ff, ohit_ff;
   logic [7:0] oid_ff, olen_ff;
   logic [7:0] ram_q;
   logic       take;

   assign in_ready = !ovalid_ff || rsp_ready;
   assign take     = in_valid && in_ready;
   assign s        = in_data.rx_byte;
   assign ridx     = {1'b0, in_data.read_index};

   always_comb begin
      phase_in = phase_ff; esc_in = esc_ff; sum_in = sum_ff; id_in = id_ff;
      len_in = len_ff; rem_in = rem_ff; wpos_in = wpos_ff;
      acc = 1'b0; ready = 1'b0; ack = 1'b0; wr_en = 1'b0;
      rd_hit = (in_data.command == CMD_READ) && (ridx < len_ff) && (ridx < BUF_LEN);
      case (in_data.command)
         CMD_BYTE: begin
            if (phase_ff != PH_HELD) begin
               acc = 1'b1;
               if (phase_ff != PH_START && phase_ff != PH_ENDDLE && s == DLE_BYTE
                   && !esc_ff) begin
                  esc_in = 1'b1;
               end else begin
                  logic [2:0] ph;
                  logic [7:0] cs;
                  ph = phase_ff;
                  cs = sum_ff;
                  if (esc_ff && s != DLE_BYTE) begin
                     ph = PH_ID;
                     cs = 8'd0;
                  end
                  esc_in   = 1'b0;
                  sum_in   = cs - s;
                  phase_in = ph;
                  case (ph)
                     PH_START: begin
                        if (s == DLE_BYTE) phase_in = PH_ID;
                        sum_in = 8'd0;
                     end
                     PH_ID: begin
                        id_in = s;
                        if (s != DLE_BYTE) phase_in = PH_LEN;
                     end
                     PH_LEN: begin
                        rem_in   = s;
                        wpos_in  = 8'd0;
                        len_in   = (s > BUF_LEN) ? BUF_LEN : s;
                        phase_in = (s == 8'd0) ? PH_SUM : PH_DATA;
                     end
                     PH_DATA: begin
                        if (wpos_ff < BUF_LEN) begin
                           wr_en   = 1'b1;
                           wpos_in = wpos_ff + 8'd1;
                        end
                        rem_in = rem_ff - 8'd1;
                        if (rem_ff == 8'd1) phase_in = PH_SUM;
                     end
                     PH_SUM: begin
                        if (sum_in != 8'd0) id_in = 8'd0;
                        phase_in = PH_ENDDLE;
                     end
                     PH_ENDDLE: if (s == DLE_BYTE) phase_in = PH_ETX;
                     PH_ETX: begin
                        if (s == ETX_BYTE) begin
                           phase_in = PH_START;
                           if (id_ff != 8'd0 && id_ff != ack_id && id_ff != nak_id) begin
                              ack      = (id_ff != pos_id);
                              ready    = 1'b1;
                              phase_in = PH_HELD;
                           end
                        end
                     end
                     default: phase_in = PH_START;
                  endcase
               end
            end
         end
         CMD_RELEASE: if (phase_ff == PH_HELD) phase_in = PH_START;
         default: ;
      endcase
   end

   dle_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_ram (
      .clock   (clock),
      .wr_en   (take && wr_en),
      .wr_addr (wpos_ff[AW-1:0]),
      .wr_data (s),
      .rd_en   (take),
      .rd_addr (ridx[AW-1:0]),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START; esc_ff <= 1'b0; sum_ff <= 8'd0; id_ff <= 8'd0;
         len_ff <= 8'd0; rem_ff <= 8'd0; wpos_ff <= 8'd0; ovalid_ff <= 1'b0;
      end else begin
         if (take) begin
            phase_ff <= phase_in; esc_ff <= esc_in; sum_ff <= sum_in; id_ff <= id_in;
            len_ff <= len_in; rem_ff <= rem_in; wpos_ff <= wpos_in;
         end
         if (in_ready) ovalid_ff <= in_valid;
      end
      if (take) begin
         oacc_ff  <= acc;   ordy_ff <= ready; oack_ff <= ack;
         oheld_ff <= (phase_in == PH_HELD);
         ohit_ff  <= rd_hit; oid_ff <= id_in; olen_ff <= len_in;
      end
   end

   assign rsp_valid         = ovalid_ff;
   assign rsp_byte_accepted = oacc_ff;
   assign rsp_frame_ready   = ordy_ff;
   assign rsp_frame_id      = oid_ff;
   assign rsp_frame_length  = olen_ff;
   assign rsp_ack_request   = oack_ff;
   assign rsp_read_data     = ohit_ff ? ram_q : 8'd0;
   assign rsp_frame_held    = oheld_ff;
endmodule

[hdl/dle_stuffed_packet_deframer.sv]
`timescale 1ns / 1ps
// DLE/ETX byte-stuffed packet receiver.
// req_ channel: one transaction per command (received byte, payload read or
// release). rsp_ channel: exactly one result transaction per request, in order.
// csr_ channel: writes ack, nak and position packet ids (index 0..2), always
// ready; write only while idle.
// Requests pass a two-entry queue into the frame engine, which updates the
// receive state and payload ram and registers the result. Each request is
// registered in the queue, then in the engine output register; one transaction
// per cycle sustained while rsp_ready is high, bounded by the state update loop.
// Payload reads come from a registered-read ram, stored length clamps to
// BUFFER_BYTES, and reads past it return zero.
// Reset clears the receive state and restores the packet id registers; the
// payload ram is not cleared.
// When rsp_ready is low the result is held, the engine stalls and the queue
// fills, after which req_ready drops; nothing is lost.
module dle_stuffed_packet_deframer import dle_pkg::*; #(
   parameter int BUFFER_BYTES = 128
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_command,
   input  logic [7:0] req_rx_byte,
   input  logic [6:0] req_read_index,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_byte_accepted,
   output logic       rsp_frame_ready,
   output logic [7:0] rsp_frame_id,
   output logic [7:0] rsp_frame_length,
   output logic       rsp_ack_request,
   output logic [7:0] rsp_read_data,
   output logic       rsp_frame_held,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);
   logic [7:0] ack_id_ff, nak_id_ff, pos_id_ff;
   req_type    q_in, q_out;
   logic       q_valid, q_ready;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ack_id_ff <= 8'd6;
         nak_id_ff <= 8'd21;
         pos_id_ff <= 8'd51;
      end else if (csr_valid) begin
         case (csr_index)
            REG_ACK_ID: ack_id_ff <= csr_data;
            REG_NAK_ID: nak_id_ff <= csr_data;
            REG_POS_ID: pos_id_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign q_in = '{command: req_command, rx_byte: req_rx_byte, read_index: req_read_index};

   dle_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (q_in),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_out)
   );

   dle_engine #(.BUFFER_BYTES(BUFFER_BYTES)) u_engine (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (q_valid),
      .in_ready          (q_ready),
      .in_data           (q_out),
      .ack_id            (ack_id_ff),
      .nak_id            (nak_id_ff),
      .pos_id            (pos_id_ff),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_byte_accepted (rsp_byte_accepted),
      .rsp_frame_ready   (rsp_frame_ready),
      .rsp_frame_id      (rsp_frame_id),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_ack_request   (rsp_ack_request),
      .rsp_read_data     (rsp_read_data),
      .rsp_frame_held    (rsp_frame_held)
   );
endmodule
